/* design/sifb_pkg.sv */
// ----------------------------------------------------------------------------
// sifb_pkg
// Shared types and constants for the stuffed information frame builder.
// ----------------------------------------------------------------------------
package sifb_pkg;

    // line codes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [7:0] CTRL_SEQ1 = 8'h40;
    localparam logic [7:0] CTRL_SEQ0 = 8'h00;

    // register map
    localparam int unsigned ADDR_W = 2;
    localparam logic [ADDR_W-1:0] REG_ADDRESS = 2'd0;
    localparam logic [7:0] ADDRESS_RESET = 8'h03;

    // depth of the queue between front and back
    localparam int unsigned JOB_DEPTH = 2;

    // input word
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       first_byte;
        logic       last_byte;
        logic       sequence_bit;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_end;
        logic       frame_end;
    } out_word_t;

    // classified job handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] addr;
        logic [7:0] parity;
        logic       first;
        logic       last;
        logic       seq;
    } job_t;

endpackage

/* design/sifb_front.sv */
// ----------------------------------------------------------------------------
// sifb_front
// Accepts payload words, keeps the running parity and builds one job per word.
// ----------------------------------------------------------------------------
module sifb_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  sifb_pkg::in_word_t item,
    input  logic [7:0]         address_byte,
    output sifb_pkg::job_t     job
);

    logic [7:0] parity_reg;
    logic [7:0] parity_next;
    logic [7:0] parity_now;

    // parity including this byte, restarted on an opening byte
    assign parity_now = (item.first_byte ? 8'h00 : parity_reg) ^ item.payload_byte;

    // job contents
    always_comb
    begin
        job.data   = item.payload_byte;
        job.addr   = address_byte;
        job.parity = parity_now;
        job.first  = item.first_byte;
        job.last   = item.last_byte;
        job.seq    = item.sequence_bit;
    end

    // parity clears after a closing byte
    always_comb
    begin
        parity_next = parity_reg;
        if (accept)
        begin
            parity_next = item.last_byte ? 8'h00 : parity_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg <= 8'h00;
        end
        else
        begin
            parity_reg <= parity_next;
        end
    end

endmodule

/* design/sifb_job_fifo.sv */
// ----------------------------------------------------------------------------
// sifb_job_fifo
// Short show-ahead queue of jobs between front and back.
// ----------------------------------------------------------------------------
module sifb_job_fifo
#(
    parameter int unsigned DEPTH = sifb_pkg::JOB_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  sifb_pkg::job_t wr_job,
    output logic           full,
    input  logic           rd_en,
    output sifb_pkg::job_t rd_job,
    output logic           empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sifb_pkg::job_t  mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

/* design/sifb_back.sv */
// ----------------------------------------------------------------------------
// sifb_back
// Walks each job through its frame fields, stuffing where needed, one byte a cycle while results are popped.
// ----------------------------------------------------------------------------
module sifb_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  sifb_pkg::job_t      job,
    output logic                job_done,
    output logic                empty,
    input  logic                pop,
    output sifb_pkg::out_word_t result
);

    // field sequencer codes
    localparam logic [2:0] ST_START = 3'd0;
    localparam logic [2:0] ST_FLAG  = 3'd1;
    localparam logic [2:0] ST_ADDR  = 3'd2;
    localparam logic [2:0] ST_CTRL  = 3'd3;
    localparam logic [2:0] ST_HCS   = 3'd4;
    localparam logic [2:0] ST_DATA  = 3'd5;
    localparam logic [2:0] ST_PAR   = 3'd6;
    localparam logic [2:0] ST_CLOSE = 3'd7;

    logic [2:0]          step_reg;
    logic [2:0]          step_next;
    logic                esc_reg;
    logic                esc_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    sifb_pkg::out_word_t out_word_reg;
    sifb_pkg::out_word_t out_word_next;

    logic [2:0] cur_step;
    logic [7:0] ctrl;
    logic [7:0] field;
    logic       stuffable;
    logic       need_esc;
    logic       field_done;
    logic       run_last;
    logic       work;

    assign empty  = !out_valid_reg;
    assign result = out_word_reg;
    assign work   = job_valid && (!out_valid_reg || pop);
    assign ctrl   = job.seq ? sifb_pkg::CTRL_SEQ1 : sifb_pkg::CTRL_SEQ0;

    // a fresh job opens with the flag or goes straight to its data
    assign cur_step = (step_reg == ST_START) ? (job.first ? ST_FLAG : ST_DATA) : step_reg;

    // field value for the current step
    always_comb
    begin
        field     = sifb_pkg::FLAG_BYTE;
        stuffable = 1'b0;
        unique case (cur_step)
            ST_START: field = job.data;
            ST_FLAG:  field = sifb_pkg::FLAG_BYTE;
            ST_ADDR:  field = job.addr;
            ST_CTRL:  field = ctrl;
            ST_HCS:
            begin
                field     = job.addr ^ ctrl;
                stuffable = 1'b1;
            end
            ST_DATA:
            begin
                field     = job.data;
                stuffable = 1'b1;
            end
            ST_PAR:
            begin
                field     = job.parity;
                stuffable = 1'b1;
            end
            ST_CLOSE: field = sifb_pkg::FLAG_BYTE;
        endcase
    end

    assign need_esc   = stuffable && !esc_reg &&
                        (field == sifb_pkg::FLAG_BYTE || field == sifb_pkg::ESC_BYTE);
    assign field_done = !need_esc;
    assign run_last   = field_done &&
                        ((cur_step == ST_DATA && !job.last) || cur_step == ST_CLOSE);
    assign job_done   = work && run_last;

    // next step and output word
    always_comb
    begin
        step_next      = step_reg;
        esc_next       = esc_reg;
        out_valid_next = out_valid_reg && !pop;
        out_word_next  = out_word_reg;
        if (work)
        begin
            out_valid_next          = 1'b1;
            out_word_next.run_end   = run_last;
            out_word_next.frame_end = (cur_step == ST_CLOSE);
            if (need_esc)
            begin
                out_word_next.line_byte = sifb_pkg::ESC_BYTE;
                esc_next                = 1'b1;
                step_next               = cur_step;
            end
            else
            begin
                out_word_next.line_byte = esc_reg ? (field ^ sifb_pkg::ESC_XOR) : field;
                esc_next                = 1'b0;
                priority case (1'b1)
                    run_last:             step_next = ST_START;
                    cur_step == ST_DATA:  step_next = ST_PAR;
                    default:              step_next = cur_step + 3'd1;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_START;
            esc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            esc_reg       <= esc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

endmodule

/* design/stuffed_info_frame_builder.sv */
// ----------------------------------------------------------------------------
// stuffed_info_frame_builder
// Byte-stuffing framer: header, stuffed payload, parity and closing flag.
//
//   channel  | handshake          | word
//   ---------+--------------------+-----------------------------------------
//   input    | push / full        | payload_byte, first_byte, last_byte, seq
//   result   | empty / pop        | line_byte, run_end, frame_end
//   config   | apb write / read   | address_byte at byte address 0
//
// One line byte leaves per cycle while the result is popped; a payload word
// produces 1 or 2 line bytes for plain data, up to 10 for a one-byte frame with escapes.
// The back sequencer sets the rate; the front takes a word every cycle while
// the job queue has room. The first line byte of a word passes the job queue
// and the output register before it is on the result ports.
// Reset clears the parity, the queue and the output stage; address_byte
// resets to 3. A low pop stalls the back only, the front keeps filling.
// ----------------------------------------------------------------------------
module stuffed_info_frame_builder
#(
    parameter int unsigned JOB_DEPTH = sifb_pkg::JOB_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  sifb_pkg::in_word_t            item,
    output logic                          empty,
    input  logic                          pop,
    output sifb_pkg::out_word_t           result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sifb_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic           address_hit;
    logic [7:0]     address_byte_reg;
    logic [7:0]     address_byte_next;
    logic           accept;
    sifb_pkg::job_t front_job;
    sifb_pkg::job_t back_job;
    logic           q_empty;
    logic           job_done;

    assign pready      = 1'b1;
    assign accept      = push && !full;
    assign address_hit = (paddr == sifb_pkg::REG_ADDRESS);
    assign prdata      = address_hit ? {24'h000000, address_byte_reg} : 32'h00000000;

    // configuration register
    always_comb
    begin
        address_byte_next = address_byte_reg;
        if (psel && penable && pwrite && pready && address_hit)
        begin
            address_byte_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_byte_reg <= sifb_pkg::ADDRESS_RESET;
        end
        else
        begin
            address_byte_reg <= address_byte_next;
        end
    end

    // front: parity and job build
    sifb_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (item),
        .address_byte (address_byte_reg),
        .job          (front_job)
    );

    // job queue
    sifb_job_fifo #(.DEPTH(JOB_DEPTH)) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_job (front_job),
        .full   (full),
        .rd_en  (job_done),
        .rd_job (back_job),
        .empty  (q_empty)
    );

    // back: field sequencer and output stage
    sifb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (back_job),
        .job_done  (job_done),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

/* design/sifb_checker.sv */
// ----------------------------------------------------------------------------
// sifb_checker
// Port-level checks on the result stream of the frame builder.
// ----------------------------------------------------------------------------
module sifb_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        empty,
    input  logic                        pop,
    input  sifb_pkg::out_word_t         result
);

    // a waiting word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result word changed while waiting");

    // closing flag ends the run and is a flag
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.frame_end) |->
            (result.run_end && result.line_byte == sifb_pkg::FLAG_BYTE))
        else $error("closing flag malformed");

    // an escape never ends a run
    a_esc: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.line_byte == sifb_pkg::ESC_BYTE) |-> !result.run_end)
        else $error("run ended on escape");

    // a waiting word is fully defined
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !$isunknown(result))
        else $error("result word has unknown bits");

endmodule

bind stuffed_info_frame_builder sifb_checker u_sifb_checker (.*);
